FILE: design/prb_pkg.sv
`timescale 1ns / 1ps

package prb_pkg;

  localparam int SLOTS_DEF       = 64;
  localparam int MAX_PAYLOAD_DEF = 2048;

  localparam int ACT_W  = 2;
  localparam int SEQ_W  = 16;
  localparam int TS_W   = 32;
  localparam int LEN_W  = 16;
  localparam int STAT_W = 2;
  localparam int SLOT_W = 6;
  localparam int OCC_W  = 7;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH  = 2'd0,
    ACT_TAKE  = 2'd1,
    ACT_FLOOR = 2'd2,
    ACT_FLUSH = 2'd3
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_IGN   = 2'd1,
    ST_ERR   = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CLEAR,
    S_SCAN,
    S_FIN
  } state_t;

  typedef struct packed {
    logic             vld;
    logic [SEQ_W-1:0] seq;
    logic [TS_W-1:0]  ts;
    logic [LEN_W-1:0] len;
  } ent_t;

endpackage

FILE: design/packet_reorder_playout_buffer.sv
`timescale 1ns / 1ps

// channel | beat moves                                           | handshake
// --------+------------------------------------------------------+---------------------
// in      | action, sequence_req, timestamp, pkt_len, floor_ex   | in_valid / in_stall
// out     | status, slot, sequence, timestamp, length, occupancy | out_valid / out_stall
//
// One input beat at a time. Push and take scan the slot memory one entry a
// cycle through its single read port. Flush and set floor sweep the memory
// through its write port. A push refused on length, floor or lateness skips
// the scan and goes straight to its result.
// After reset the slot memory is cleared before in_stall drops.
// A finished result waits in the output register; the next beat is taken
// meanwhile, and only its final step waits while out_stall holds.

module packet_reorder_playout_buffer #(
  parameter int SLOTS       = prb_pkg::SLOTS_DEF,
  parameter int MAX_PAYLOAD = prb_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,

  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [prb_pkg::ACT_W-1:0]   in_action,
  input  logic [prb_pkg::SEQ_W-1:0]   in_sequence_req,
  input  logic [prb_pkg::TS_W-1:0]    in_timestamp,
  input  logic [prb_pkg::LEN_W-1:0]   in_pkt_len,
  input  logic                        in_floor_exclusive,

  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [prb_pkg::STAT_W-1:0]  out_status,
  output logic [prb_pkg::SLOT_W-1:0]  out_slot,
  output logic [prb_pkg::SEQ_W-1:0]   out_sequence,
  output logic [prb_pkg::TS_W-1:0]    out_timestamp,
  output logic [prb_pkg::LEN_W-1:0]   out_length,
  output logic [prb_pkg::OCC_W-1:0]   out_occupancy
);

  import prb_pkg::*;

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);

  state_t           state_r, state_nxt;

  action_t          act_r, act_nxt;
  logic [SEQ_W-1:0] seq_r, seq_nxt;
  logic [TS_W-1:0]  ts_r, ts_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             excl_r, excl_nxt;
  status_t          pre_code_r, pre_code_nxt;
  logic             fl_pend_r, fl_pend_nxt;

  logic [CNT_W-1:0] rd_cnt_r, rd_cnt_nxt;
  logic             chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0] chk_idx_r, chk_idx_nxt;
  logic [IDX_W-1:0] clr_idx_r, clr_idx_nxt;

  logic             dup_r, dup_nxt;
  logic             have_free_r, have_free_nxt;
  logic [IDX_W-1:0] free_idx_r, free_idx_nxt;
  logic             found_r, found_nxt;
  logic [IDX_W-1:0] best_idx_r, best_idx_nxt;
  logic [SEQ_W-1:0] best_dist_r, best_dist_nxt;
  logic [SEQ_W-1:0] best_seq_r, best_seq_nxt;
  logic [TS_W-1:0]  best_ts_r, best_ts_nxt;
  logic [LEN_W-1:0] best_len_r, best_len_nxt;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SEQ_W-1:0] exp_r, exp_nxt;
  logic             playing_r, playing_nxt;
  logic             seq_known_r, seq_known_nxt;
  logic             floor_act_r, floor_act_nxt;
  logic [TS_W-1:0]  floor_ts_r, floor_ts_nxt;
  logic             floor_excl_r, floor_excl_nxt;

  logic             out_valid_r, out_valid_nxt;
  status_t          out_status_r, out_status_nxt;
  logic [SLOT_W-1:0] out_slot_r, out_slot_nxt;
  logic [SEQ_W-1:0] out_seq_r, out_seq_nxt;
  logic [TS_W-1:0]  out_ts_r, out_ts_nxt;
  logic [LEN_W-1:0] out_len_r, out_len_nxt;
  logic [OCC_W-1:0] out_occ_r, out_occ_nxt;

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  ent_t             mem_wdata;
  ent_t             rd_ent;

  logic             in_acc;
  logic             out_free;
  logic             commit;
  logic             last_chk;
  logic             clr_last;
  logic             push_ok;
  logic             scan_issue;

  logic [TS_W-1:0]  floor_diff;
  logic [SEQ_W-1:0] in_dist;
  logic [SEQ_W-1:0] held_dist;
  logic [SEQ_W-1:0] ent_dist;
  logic             bad_len;
  logic             before_floor;
  logic             late;
  status_t          pre_code;

  prb_ram #(
    .WIDTH ($bits(ent_t)),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (rd_cnt_r[IDX_W-1:0]),
    .rdata (rd_ent)
  );

  assign in_acc     = in_valid && !in_stall;
  assign out_free   = !out_valid_r || !out_stall;
  assign commit     = (state_r == S_FIN) && out_free;
  assign last_chk   = chk_vld_r && (chk_idx_r == IDX_W'(SLOTS - 1));
  assign clr_last   = clr_idx_r == IDX_W'(SLOTS - 1);
  assign push_ok    = (pre_code_r == ST_OK) && !dup_r && have_free_r;
  assign scan_issue = (state_r == S_SCAN) && (rd_cnt_r < CNT_W'(SLOTS));

  assign floor_diff   = in_timestamp - floor_ts_r;
  assign in_dist      = in_sequence_req - exp_r;
  assign held_dist    = seq_r - exp_r;
  assign ent_dist     = rd_ent.seq - exp_r;
  assign bad_len      = (in_pkt_len == '0) || (in_pkt_len > LEN_W'(MAX_PAYLOAD));
  assign before_floor = floor_act_r &&
                        (floor_diff[TS_W-1] || ((floor_diff == '0) && floor_excl_r));
  assign late         = seq_known_r && playing_r && in_dist[SEQ_W-1];

  always_comb begin
    if (bad_len) begin
      pre_code = ST_ERR;
    end else if (before_floor || late) begin
      pre_code = ST_IGN;
    end else begin
      pre_code = ST_OK;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (action_t'(in_action))
            ACT_PUSH: state_nxt = (pre_code == ST_OK) ? S_SCAN : S_FIN;
            ACT_TAKE: state_nxt = S_SCAN;
            default:  state_nxt = S_CLEAR;
          endcase
        end
      end
      S_CLEAR: begin
        if (clr_last) begin
          state_nxt = fl_pend_r ? S_FIN : S_IDLE;
        end
      end
      S_SCAN: begin
        if (last_chk) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs of the control: stall and memory write port
  always_comb begin
    in_stall  = 1'b1;
    mem_we    = 1'b0;
    mem_waddr = clr_idx_r;
    mem_wdata = '0;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
      end
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_FIN: begin
        if (commit && (act_r == ACT_PUSH) && push_ok) begin
          mem_we        = 1'b1;
          mem_waddr     = free_idx_r;
          mem_wdata.vld = 1'b1;
          mem_wdata.seq = seq_r;
          mem_wdata.ts  = ts_r;
          mem_wdata.len = len_r;
        end else if (commit && (act_r == ACT_TAKE) && found_r) begin
          mem_we    = 1'b1;
          mem_waddr = best_idx_r;
        end
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // datapath
  always_comb begin
    act_nxt        = act_r;
    seq_nxt        = seq_r;
    ts_nxt         = ts_r;
    len_nxt        = len_r;
    excl_nxt       = excl_r;
    pre_code_nxt   = pre_code_r;
    fl_pend_nxt    = fl_pend_r;
    rd_cnt_nxt     = rd_cnt_r;
    chk_vld_nxt    = scan_issue;
    chk_idx_nxt    = rd_cnt_r[IDX_W-1:0];
    clr_idx_nxt    = clr_idx_r;
    dup_nxt        = dup_r;
    have_free_nxt  = have_free_r;
    free_idx_nxt   = free_idx_r;
    found_nxt      = found_r;
    best_idx_nxt   = best_idx_r;
    best_dist_nxt  = best_dist_r;
    best_seq_nxt   = best_seq_r;
    best_ts_nxt    = best_ts_r;
    best_len_nxt   = best_len_r;
    cnt_nxt        = cnt_r;
    exp_nxt        = exp_r;
    playing_nxt    = playing_r;
    seq_known_nxt  = seq_known_r;
    floor_act_nxt  = floor_act_r;
    floor_ts_nxt   = floor_ts_r;
    floor_excl_nxt = floor_excl_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_seq_nxt    = out_seq_r;
    out_ts_nxt     = out_ts_r;
    out_len_nxt    = out_len_r;
    out_occ_nxt    = out_occ_r;

    if (in_acc) begin
      act_nxt       = action_t'(in_action);
      seq_nxt       = in_sequence_req;
      ts_nxt        = in_timestamp;
      len_nxt       = in_pkt_len;
      excl_nxt      = in_floor_exclusive;
      pre_code_nxt  = pre_code;
      fl_pend_nxt   = (action_t'(in_action) == ACT_FLOOR) ||
                      (action_t'(in_action) == ACT_FLUSH);
      rd_cnt_nxt    = '0;
      clr_idx_nxt   = '0;
      dup_nxt       = 1'b0;
      have_free_nxt = 1'b0;
      found_nxt     = 1'b0;
    end

    if (scan_issue) begin
      rd_cnt_nxt = rd_cnt_r + 1'b1;
    end

    if (state_r == S_CLEAR) begin
      clr_idx_nxt = clr_idx_r + 1'b1;
    end

    // fold one entry into the scan
    if (chk_vld_r) begin
      if (act_r == ACT_PUSH) begin
        if (rd_ent.vld && (rd_ent.seq == seq_r)) begin
          dup_nxt = 1'b1;
        end
        if (!rd_ent.vld && !have_free_r) begin
          have_free_nxt = 1'b1;
          free_idx_nxt  = chk_idx_r;
        end
      end else if (rd_ent.vld && (!found_r || (ent_dist < best_dist_r))) begin
        found_nxt     = 1'b1;
        best_idx_nxt  = chk_idx_r;
        best_dist_nxt = ent_dist;
        best_seq_nxt  = rd_ent.seq;
        best_ts_nxt   = rd_ent.ts;
        best_len_nxt  = rd_ent.len;
      end
    end

    if (commit) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = ST_OK;
      out_slot_nxt   = '0;
      out_seq_nxt    = '0;
      out_ts_nxt     = '0;
      out_len_nxt    = '0;
      case (act_r)
        ACT_PUSH: begin
          if (pre_code_r != ST_OK) begin
            out_status_nxt = pre_code_r;
          end else if (dup_r) begin
            out_status_nxt = ST_IGN;
          end else if (!have_free_r) begin
            out_status_nxt = ST_ERR;
          end else begin
            out_slot_nxt  = SLOT_W'(free_idx_r);
            cnt_nxt       = cnt_r + 1'b1;
            seq_known_nxt = 1'b1;
            if (!seq_known_r || (!playing_r && held_dist[SEQ_W-1])) begin
              exp_nxt = seq_r;
            end
          end
        end
        ACT_TAKE: begin
          if (!found_r) begin
            out_status_nxt = ST_EMPTY;
          end else begin
            out_slot_nxt  = SLOT_W'(best_idx_r);
            out_seq_nxt   = best_seq_r;
            out_ts_nxt    = best_ts_r;
            out_len_nxt   = best_len_r;
            exp_nxt       = best_seq_r + 1'b1;
            playing_nxt   = 1'b1;
            floor_act_nxt = 1'b0;
            if (cnt_r != '0) begin
              cnt_nxt = cnt_r - 1'b1;
            end
          end
        end
        default: begin
          cnt_nxt       = '0;
          exp_nxt       = '0;
          playing_nxt   = 1'b0;
          seq_known_nxt = 1'b0;
          floor_act_nxt = (act_r == ACT_FLOOR);
          if (act_r == ACT_FLOOR) begin
            floor_ts_nxt   = ts_r;
            floor_excl_nxt = excl_r;
          end
        end
      endcase
      out_occ_nxt = OCC_W'(cnt_nxt);
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      fl_pend_r    <= 1'b0;
      rd_cnt_r     <= '0;
      chk_vld_r    <= 1'b0;
      clr_idx_r    <= '0;
      cnt_r        <= '0;
      exp_r        <= '0;
      playing_r    <= 1'b0;
      seq_known_r  <= 1'b0;
      floor_act_r  <= 1'b0;
      floor_ts_r   <= '0;
      floor_excl_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fl_pend_r    <= fl_pend_nxt;
      rd_cnt_r     <= rd_cnt_nxt;
      chk_vld_r    <= chk_vld_nxt;
      clr_idx_r    <= clr_idx_nxt;
      cnt_r        <= cnt_nxt;
      exp_r        <= exp_nxt;
      playing_r    <= playing_nxt;
      seq_known_r  <= seq_known_nxt;
      floor_act_r  <= floor_act_nxt;
      floor_ts_r   <= floor_ts_nxt;
      floor_excl_r <= floor_excl_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r        <= act_nxt;
    seq_r        <= seq_nxt;
    ts_r         <= ts_nxt;
    len_r        <= len_nxt;
    excl_r       <= excl_nxt;
    pre_code_r   <= pre_code_nxt;
    chk_idx_r    <= chk_idx_nxt;
    dup_r        <= dup_nxt;
    have_free_r  <= have_free_nxt;
    free_idx_r   <= free_idx_nxt;
    found_r      <= found_nxt;
    best_idx_r   <= best_idx_nxt;
    best_dist_r  <= best_dist_nxt;
    best_seq_r   <= best_seq_nxt;
    best_ts_r    <= best_ts_nxt;
    best_len_r   <= best_len_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_seq_r    <= out_seq_nxt;
    out_ts_r     <= out_ts_nxt;
    out_len_r    <= out_len_nxt;
    out_occ_r    <= out_occ_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_slot      = out_slot_r;
  assign out_sequence  = out_seq_r;
  assign out_timestamp = out_ts_r;
  assign out_length    = out_len_r;
  assign out_occupancy = out_occ_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(SLOTS))
    else $error("held count above slot count");

  a_fin_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) && out_valid_r && out_stall |=> (state_r == S_FIN))
    else $error("result committed over a stalled output beat");

  a_take_dec: assert property (@(posedge clk) disable iff (!rst_n)
    commit && (act_r == ACT_TAKE) && found_r |=> cnt_r == $past(cnt_r) - 1'b1)
    else $error("delivered take did not drop the count");

  a_no_wr_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> !mem_we)
    else $error("slot memory written during a scan");

endmodule

FILE: design/prb_ram.sv
`timescale 1ns / 1ps

module prb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: test/playout_check_pkg.sv
`timescale 1ns / 1ps

package playout_check_pkg;
  import prb_pkg::*;

  typedef struct {
    status_t           status;
    bit [SLOT_W-1:0]   slot;
    bit [SEQ_W-1:0]    seq;
    bit [TS_W-1:0]     ts;
    bit [LEN_W-1:0]    len;
    bit [OCC_W-1:0]    occ;
  } playout_result_t;

  class playout_scoreboard;
    bit               slot_used [SLOTS_DEF];
    bit [SEQ_W-1:0]   slot_seq  [SLOTS_DEF];
    bit [TS_W-1:0]    slot_ts   [SLOTS_DEF];
    bit [LEN_W-1:0]   slot_len  [SLOTS_DEF];
    int               held;
    bit [SEQ_W-1:0]   next_seq;
    bit               started;
    bit               seq_locked;
    bit               floor_on;
    bit               floor_excl;
    bit [TS_W-1:0]    floor_ts;
    playout_result_t  due_q [$];
    int               errors;
    int               results_seen;

    function new();
      clear_slots();
      floor_ts     = '0;
      floor_excl   = 1'b0;
      errors       = 0;
      results_seen = 0;
    endfunction

    function void clear_slots();
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      held       = 0;
      next_seq   = '0;
      started    = 1'b0;
      seq_locked = 1'b0;
      floor_on   = 1'b0;
    endfunction

    function playout_result_t blank_result();
      playout_result_t r;
      r.status = ST_OK;
      r.slot   = '0;
      r.seq    = '0;
      r.ts     = '0;
      r.len    = '0;
      r.occ    = '0;
      return r;
    endfunction

    function playout_result_t place_packet(bit [SEQ_W-1:0] seq, bit [TS_W-1:0] ts,
                                           bit [LEN_W-1:0] len);
      playout_result_t r;
      bit [TS_W-1:0]   ts_gap;
      bit [SEQ_W-1:0]  lead;
      bit              behind;
      bit              have_free;
      int              free_idx;
      r = blank_result();
      if (len == 0 || len > MAX_PAYLOAD_DEF) begin
        r.status = ST_ERR;
        return r;
      end
      ts_gap = ts - floor_ts;
      if (floor_on && (ts_gap[TS_W-1] || (ts_gap == 0 && floor_excl))) begin
        r.status = ST_IGN;
        return r;
      end
      lead   = seq - next_seq;
      behind = lead[SEQ_W-1];
      if (seq_locked && started && behind) begin
        r.status = ST_IGN;
        return r;
      end
      have_free = 1'b0;
      free_idx  = 0;
      for (int i = 0; i < SLOTS_DEF; i++) begin
        if (slot_used[i]) begin
          if (slot_seq[i] == seq) begin
            r.status = ST_IGN;
            return r;
          end
        end else if (!have_free) begin
          have_free = 1'b1;
          free_idx  = i;
        end
      end
      if (!have_free) begin
        r.status = ST_ERR;
        return r;
      end
      if (!seq_locked || (!started && behind)) next_seq = seq;
      seq_locked          = 1'b1;
      slot_used[free_idx] = 1'b1;
      slot_seq[free_idx]  = seq;
      slot_ts[free_idx]   = ts;
      slot_len[free_idx]  = len;
      held++;
      r.slot = SLOT_W'(free_idx);
      return r;
    endfunction

    function playout_result_t deliver_next();
      playout_result_t r;
      bit [SEQ_W-1:0]  d;
      bit [SEQ_W-1:0]  best_d;
      int              best;
      r      = blank_result();
      best   = -1;
      best_d = '0;
      for (int i = 0; i < SLOTS_DEF; i++) begin
        if (slot_used[i]) begin
          d = slot_seq[i] - next_seq;
          if (best < 0 || d < best_d) begin
            best   = i;
            best_d = d;
          end
        end
      end
      if (best < 0) begin
        r.status = ST_EMPTY;
        return r;
      end
      r.slot          = SLOT_W'(best);
      r.seq           = slot_seq[best];
      r.ts            = slot_ts[best];
      r.len           = slot_len[best];
      next_seq        = slot_seq[best] + 1'b1;
      started         = 1'b1;
      floor_on        = 1'b0;
      slot_used[best] = 1'b0;
      if (held > 0) held--;
      return r;
    endfunction

    function void note_beat(action_t act, bit [SEQ_W-1:0] seq, bit [TS_W-1:0] ts,
                            bit [LEN_W-1:0] len, bit excl);
      playout_result_t r;
      r = blank_result();
      case (act)
        ACT_PUSH: r = place_packet(seq, ts, len);
        ACT_TAKE: r = deliver_next();
        ACT_FLOOR: begin
          clear_slots();
          floor_ts   = ts;
          floor_excl = excl;
          floor_on   = 1'b1;
        end
        default: clear_slots();
      endcase
      r.occ = OCC_W'(held);
      due_q.push_back(r);
    endfunction

    function int due_count();
      return due_q.size();
    endfunction

    task report_mismatch(string what, logic [TS_W-1:0] got, logic [TS_W-1:0] want);
      errors++;
      if (errors <= 100)
        $display("tb_top: result %0d %s mismatch: got %h, want %h",
                 results_seen, what, got, want);
    endtask

    task check_result(logic [STAT_W-1:0] status, logic [SLOT_W-1:0] slot,
                      logic [SEQ_W-1:0] seq, logic [TS_W-1:0] ts,
                      logic [LEN_W-1:0] len, logic [OCC_W-1:0] occ);
      playout_result_t want;
      results_seen++;
      if (due_q.size() == 0) begin
        report_mismatch("unexpected beat", TS_W'(status), '0);
        return;
      end
      want = due_q.pop_front();
      if (status !== want.status) report_mismatch("status", TS_W'(status), TS_W'(want.status));
      if (slot !== want.slot)     report_mismatch("slot", TS_W'(slot), TS_W'(want.slot));
      if (seq !== want.seq)       report_mismatch("sequence", TS_W'(seq), TS_W'(want.seq));
      if (ts !== want.ts)         report_mismatch("timestamp", ts, want.ts);
      if (len !== want.len)       report_mismatch("length", TS_W'(len), TS_W'(want.len));
      if (occ !== want.occ)       report_mismatch("occupancy", TS_W'(occ), TS_W'(want.occ));
    endtask
  endclass

endpackage

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import prb_pkg::*;
  import playout_check_pkg::*;

  localparam int TOTAL_BEATS = 700;
  localparam int CYCLE_LIMIT = 1000000;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [ACT_W-1:0]  in_action;
  logic [SEQ_W-1:0]  in_sequence_req;
  logic [TS_W-1:0]   in_timestamp;
  logic [LEN_W-1:0]  in_pkt_len;
  logic              in_floor_exclusive;
  logic              out_valid;
  logic              out_stall;
  logic [STAT_W-1:0] out_status;
  logic [SLOT_W-1:0] out_slot;
  logic [SEQ_W-1:0]  out_sequence;
  logic [TS_W-1:0]   out_timestamp;
  logic [LEN_W-1:0]  out_length;
  logic [OCC_W-1:0]  out_occupancy;

  playout_scoreboard sb = new();
  int                beats_sent = 0;
  int                cycles = 0;
  bit                in_calm = 1'b0;
  bit                out_calm = 1'b0;
  int unsigned       hold_cnt = 0;

  packet_reorder_playout_buffer i_dut (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("packet_reorder_playout_buffer verification failed");
      $finish;
    end
  end

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  function automatic bit [LEN_W-1:0] good_len();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return 16'd1;
    if (r == 1) return 16'(MAX_PAYLOAD_DEF);
    return 16'($urandom_range(1, MAX_PAYLOAD_DEF));
  endfunction

  function automatic bit [LEN_W-1:0] bad_len();
    if ($urandom_range(0, 2) == 0) return '0;
    return 16'($urandom_range(MAX_PAYLOAD_DEF + 1, 65535));
  endfunction

  task automatic send_beat(action_t act, bit [SEQ_W-1:0] seq, bit [TS_W-1:0] ts,
                           bit [LEN_W-1:0] len, bit excl);
    int unsigned gap;
    gap = in_calm ? 0 : idle_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_action          <= act;
    in_sequence_req    <= seq;
    in_timestamp       <= ts;
    in_pkt_len         <= len;
    in_floor_exclusive <= excl;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_beat(act, seq, ts, len, excl);
    beats_sent++;
  endtask

  task automatic send_take();
    send_beat(ACT_TAKE, 16'($urandom), $urandom, 16'($urandom), 1'($urandom));
  endtask

  task automatic send_flush();
    send_beat(ACT_FLUSH, 16'($urandom), $urandom, 16'($urandom), 1'($urandom));
  endtask

  // hold the sender until every result is back
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.due_count() != 0);
  endtask

  task automatic run_directed();
    send_take();
    send_beat(ACT_PUSH, 16'h0100, 32'd10, 16'd0, 1'b0);
    send_beat(ACT_PUSH, 16'h0100, 32'd10, 16'(MAX_PAYLOAD_DEF + 1), 1'b0);
    send_beat(ACT_PUSH, 16'h0100, 32'd10, 16'hFFFF, 1'b1);
    send_beat(ACT_PUSH, 16'hFFFF, 32'hFFFF_FFFF, 16'(MAX_PAYLOAD_DEF), 1'b0);
    send_beat(ACT_PUSH, 16'h0000, 32'h0, 16'd1, 1'b0);
    send_beat(ACT_PUSH, 16'hFFFF, 32'd5, 16'd7, 1'b0);
    send_beat(ACT_PUSH, 16'hFFF0, 32'd6, 16'd100, 1'b0);
    send_take();
    send_beat(ACT_PUSH, 16'hFFF0, 32'd7, 16'd100, 1'b0);
    send_take();
    send_take();
    send_take();
    send_beat(ACT_FLOOR, 16'h0, 32'd1000, 16'h0, 1'b1);
    send_beat(ACT_PUSH, 16'h0005, 32'd1000, 16'd64, 1'b0);
    send_beat(ACT_PUSH, 16'h0005, 32'd999, 16'd64, 1'b0);
    send_beat(ACT_PUSH, 16'h0005, 32'd1001, 16'd64, 1'b0);
    send_beat(ACT_FLOOR, 16'hFFFF, 32'h8000_0000, 16'hFFFF, 1'b0);
    send_beat(ACT_PUSH, 16'h1234, 32'h8000_0000, 16'd20, 1'b0);
    send_beat(ACT_PUSH, 16'h1300, 32'h7FFF_FFFF, 16'd20, 1'b0);
    send_beat(ACT_PUSH, 16'h1301, 32'h0, 16'd20, 1'b0);
    send_beat(ACT_PUSH, 16'h1302, 32'hFFFF_FFFF, 16'd20, 1'b0);
    send_take();
    send_beat(ACT_PUSH, 16'h1235, 32'h0, 16'd30, 1'b1);
    send_beat(ACT_PUSH, 16'h1000, 32'h0, 16'd30, 1'b0);
    send_flush();
  endtask

  task automatic run_stream();
    bit [SEQ_W-1:0] base;
    bit [SEQ_W-1:0] s;
    bit [TS_W-1:0]  ts0;
    int             n;
    int             k;
    int             r;
    send_flush();
    base = ($urandom_range(0, 3) == 0) ? 16'hFFE0 : 16'($urandom);
    ts0  = $urandom;
    n    = $urandom_range(12, 40);
    k    = 0;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        send_take();
      end else if (r < 40) begin
        send_beat(ACT_PUSH, base + 16'(k), ts0, bad_len(), 1'($urandom));
      end else if (r < 46) begin
        s = base + 16'($urandom_range(0, k));
        send_beat(ACT_PUSH, s, ts0 + 32'(s - base) * 160, good_len(), 1'b0);
      end else begin
        s = base + 16'(k + $urandom_range(0, 3));
        send_beat(ACT_PUSH, s, ts0 + 32'(s - base) * 160, good_len(), 1'($urandom));
        k++;
      end
    end
  endtask

  task automatic run_fill();
    bit [SEQ_W-1:0] base;
    bit [TS_W-1:0]  ts0;
    send_flush();
    base = 16'($urandom);
    ts0  = $urandom;
    for (int i = 0; i < SLOTS_DEF + 2; i++)
      send_beat(ACT_PUSH, base + 16'(i), ts0 + 32'(i), good_len(), 1'b0);
    send_beat(ACT_PUSH, base, ts0, good_len(), 1'b0);
    repeat ($urandom_range(1, 6)) send_take();
    for (int i = 0; i < 3; i++)
      send_beat(ACT_PUSH, base + 16'(SLOTS_DEF + 2 + i), ts0, good_len(), 1'b0);
  endtask

  task automatic run_floor();
    bit [SEQ_W-1:0] base;
    bit [TS_W-1:0]  fl;
    int             n;
    int             r;
    fl = $urandom;
    send_beat(ACT_FLOOR, 16'($urandom), fl, 16'($urandom), 1'($urandom));
    base = 16'($urandom);
    n    = $urandom_range(8, 20);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 12)
        send_take();
      else if (r < 30)
        send_beat(ACT_PUSH, base + 16'(i), $urandom, good_len(), 1'($urandom));
      else
        send_beat(ACT_PUSH, base + 16'(i), fl + 32'($urandom_range(0, 6)) - 32'd3,
                  good_len(), 1'($urandom));
    end
  endtask

  task automatic run_noise();
    repeat ($urandom_range(4, 12))
      send_beat(action_t'($urandom_range(0, 3)), 16'($urandom), $urandom,
                16'($urandom), 1'($urandom));
  endtask

  initial begin
    rst_n              <= 1'b0;
    in_valid           <= 1'b0;
    in_action          <= ACT_PUSH;
    in_sequence_req    <= '0;
    in_timestamp       <= '0;
    in_pkt_len         <= '0;
    in_floor_exclusive <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    settle();
    while (beats_sent < TOTAL_BEATS) begin
      in_calm = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: run_stream();
        5, 6: run_fill();
        7: run_floor();
        8: run_noise();
        default: begin
          send_flush();
          settle();
        end
      endcase
    end
    settle();
    repeat (SLOTS_DEF + 8) @(posedge clk);
    if (sb.errors == 0)
      $display("packet_reorder_playout_buffer verification clean");
    else
      $display("packet_reorder_playout_buffer verification failed");
    $finish;
  end

  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_stall === 1'b0)
        sb.check_result(out_status, out_slot, out_sequence, out_timestamp,
                        out_length, out_occupancy);
      if ($urandom_range(0, 299) == 0) out_calm = !out_calm;
      if (hold_cnt != 0) begin
        hold_cnt--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (!out_calm && $urandom_range(0, 2) == 0) hold_cnt = idle_len();
      end
    end
  end

endmodule
